// ===== rtl/uart_login_command_interpreter_core_defines.svh =====
// Assertion macros for the login interpreter RTL, used by the frame engine.
`ifndef UART_LOGIN_COMMAND_INTERPRETER_CORE_DEFINES_SVH
`define UART_LOGIN_COMMAND_INTERPRETER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off while rst is high.
`define ULI_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("uli: assertion failed");
// Next-cycle implication, sampled on clk, off while rst is high.
`define ULI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("uli: assertion failed");
`else
`define ULI_ASSERT_IMPL(label, ante, cons)
`define ULI_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== rtl/uli_pkg.sv =====
// Types and constants for the login command interpreter.
package uli_pkg;

  localparam int unsigned MAX_FRAME_DEF  = 250;
  localparam int unsigned NAME_CHARS_DEF = 20;
  localparam int unsigned NAME_CHARS_MAX = 20;
  localparam int unsigned CRED_BITS      = NAME_CHARS_MAX * 8;
  localparam int unsigned CHARS_W        = 5;

  localparam logic [CHARS_W-1:0] DEVICE_LIMIT = 5'd9;
  localparam logic [CHARS_W-1:0] STATUS_LIMIT = 5'd5;
  localparam logic [7:0] LOGIN_MIN_LEN = 8'd9;
  localparam logic [7:0] CMD_MIN_LEN   = 8'd7;
  localparam logic [7:0] LOGIN_PREFIX_LAST = 8'd5;
  localparam logic [7:0] CMD_PREFIX_LAST   = 8'd3;
  localparam logic [7:0] SEP_CHAR = "#";

  localparam logic [63:0] CRED_RESET_LOW = 64'd474215179361;  // "admin"

  localparam logic [7:0] LOGIN_PREFIX [6] = '{"l", "o", "g", "i", "n", "#"};
  localparam logic [7:0] CMD_PREFIX   [4] = '{"c", "m", "d", "#"};

  localparam logic [7:0] DEVICE_NAMES [3][10] = '{
    '{"L", "E", "D", "1", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"B", "E", "E", "P", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"l", "o", "g", "i", "n", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };
  localparam logic [7:0] STATUS_NAMES [3][6] = '{
    '{"O", "N", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"O", "F", "F", 8'h00, 8'h00, 8'h00},
    '{"o", "u", "t", 8'h00, 8'h00, 8'h00}
  };

  typedef enum logic [2:0] {
    CFG_USER_LOW  = 3'd0,
    CFG_USER_MID  = 3'd1,
    CFG_USER_HIGH = 3'd2,
    CFG_PASS_LOW  = 3'd3,
    CFG_PASS_MID  = 3'd4,
    CFG_PASS_HIGH = 3'd5
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_LOGIN_OK   = 3'd0,
    ST_BAD_CRED   = 3'd1,
    ST_FIELD_LONG = 3'd2,
    ST_TOO_SHORT  = 3'd3,
    ST_CMD_OK     = 3'd4,
    ST_CMD_ERR    = 3'd5,
    ST_DEV_LONG   = 3'd6,
    ST_STAT_LONG  = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    STG_PREFIX = 2'd0,
    STG_FIRST  = 2'd1,
    STG_SECOND = 2'd2,
    STG_DONE   = 2'd3
  } stage_t;

  typedef enum logic [1:0] {
    PEND_NONE   = 2'd0,
    PEND_FIRST  = 2'd1,
    PEND_SECOND = 2'd2
  } pend_t;

  typedef struct packed {
    logic [CRED_BITS-1:0] user;
    logic [CRED_BITS-1:0] pass;
  } cred_t;

  typedef struct packed {
    status_t status_code;
    logic    led_on;
    logic    beep_on;
    logic    logged_in;
  } result_t;

endpackage

// ===== rtl/uli_cfg_regs.sv =====
// Credential register file written through the configuration channel.
module uli_cfg_regs (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [63:0]          cfg_data,
  output uli_pkg::cred_t       creds
);

  logic [63:0] user_low, user_mid, pass_low, pass_mid;
  logic [31:0] user_high, pass_high;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      user_low  <= uli_pkg::CRED_RESET_LOW;
      user_mid  <= '0;
      user_high <= '0;
      pass_low  <= uli_pkg::CRED_RESET_LOW;
      pass_mid  <= '0;
      pass_high <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        uli_pkg::CFG_USER_LOW:  user_low  <= cfg_data;
        uli_pkg::CFG_USER_MID:  user_mid  <= cfg_data;
        uli_pkg::CFG_USER_HIGH: user_high <= cfg_data[31:0];
        uli_pkg::CFG_PASS_LOW:  pass_low  <= cfg_data;
        uli_pkg::CFG_PASS_MID:  pass_mid  <= cfg_data;
        uli_pkg::CFG_PASS_HIGH: pass_high <= cfg_data[31:0];
        default: ;  // unused indexes are dropped
      endcase
    end
  end

  // character k sits at bits 8k+7:8k
  assign creds.user = {user_high, user_mid, user_low};
  assign creds.pass = {pass_high, pass_mid, pass_low};

endmodule

// ===== rtl/uli_frame_engine.sv =====
// Per-byte frame parser, credential/command matcher and session state.
`include "uart_login_command_interpreter_core_defines.svh"

module uli_frame_engine #(
  parameter int unsigned MAX_FRAME  = uli_pkg::MAX_FRAME_DEF,
  parameter int unsigned NAME_CHARS = uli_pkg::NAME_CHARS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step_en,
  input  logic [7:0]          rx_byte,
  input  logic                frame_end,
  input  uli_pkg::cred_t      creds,
  output logic                res_valid,
  output uli_pkg::result_t    res
);

  localparam int unsigned CW = uli_pkg::CHARS_W;

  // frame state
  logic [7:0]       frame_count, frame_count_next;
  uli_pkg::stage_t  stage, stage_next;
  logic [CW-1:0]    chars, chars_next;
  logic             prefix_good, prefix_good_next;
  logic [2:0]       match1, match1_next;
  logic [2:0]       match2, match2_next;
  uli_pkg::pend_t   pend, pend_next;
  logic             sealed, sealed_next;
  // session state
  logic             session, session_next;
  logic             lamp, lamp_next;
  logic             buzz, buzz_next;

  function automatic logic [7:0] cred_char(logic [uli_pkg::CRED_BITS-1:0] c,
                                           logic [CW-1:0] k);
    logic [7:0] r;
    r = '0;
    for (int i = 0; i < int'(uli_pkg::NAME_CHARS_MAX); i++) begin
      if (i < int'(NAME_CHARS) && k == CW'(i)) r = c[i*8 +: 8];
    end
    return r;
  endfunction

  // expected character k of candidate cand in field fld (0 first, 1 second)
  function automatic logic [7:0] target(logic fld, logic [1:0] cand, logic [CW-1:0] k,
                                        logic sess, uli_pkg::cred_t cr);
    logic [7:0] r;
    r = '0;
    if (!sess) begin
      if (cand == 2'd0) r = fld ? cred_char(cr.pass, k) : cred_char(cr.user, k);
    end else if (!fld) begin
      if (k < CW'(10)) r = uli_pkg::DEVICE_NAMES[cand][k[3:0]];
    end else begin
      if (k < CW'(6)) r = uli_pkg::STATUS_NAMES[cand][k[2:0]];
    end
    return r;
  endfunction

  // field ends at position k: drop candidates that still expect a character
  function automatic logic [2:0] close_mask(logic [2:0] m, logic fld, logic [CW-1:0] k,
                                            logic seal, logic sess, uli_pkg::cred_t cr);
    logic [2:0] r;
    r = m;
    if (!seal) begin
      for (int c = 0; c < 3; c++) begin
        if (target(fld, 2'(c), k, sess, cr) != 8'h00) r[c] = 1'b0;
      end
    end
    return r;
  endfunction

  function automatic logic [2:0] feed_mask(logic [2:0] m, logic fld, logic [CW-1:0] k,
                                           logic [7:0] ch, logic seal, logic sess,
                                           uli_pkg::cred_t cr);
    logic [2:0] r;
    r = m;
    if (!seal) begin
      if (ch == 8'h00) begin
        r = close_mask(m, fld, k, 1'b0, sess, cr);
      end else begin
        for (int c = 0; c < 3; c++) begin
          if (target(fld, 2'(c), k, sess, cr) != ch) r[c] = 1'b0;
        end
      end
    end
    return r;
  endfunction

  function automatic logic [7:0] prefix_char(logic sess, logic [7:0] pos);
    logic [7:0] r;
    r = '0;
    if (sess) r = uli_pkg::CMD_PREFIX[pos[1:0]];
    else if (pos < 8'd6) r = uli_pkg::LOGIN_PREFIX[pos[2:0]];
    return r;
  endfunction

  always_comb begin
    logic [CW-1:0] limit;
    logic          fld;
    frame_count_next = frame_count;
    stage_next       = stage;
    chars_next       = chars;
    prefix_good_next = prefix_good;
    match1_next      = match1;
    match2_next      = match2;
    pend_next        = pend;
    sealed_next      = sealed;
    session_next     = session;
    lamp_next        = lamp;
    buzz_next        = buzz;
    res_valid        = 1'b0;
    res.status_code  = uli_pkg::ST_CMD_ERR;
    limit            = '0;
    fld              = (stage == uli_pkg::STG_SECOND);

    if (step_en) begin
      if ({1'b0, frame_count} + 9'd1 >= 9'(MAX_FRAME)) begin
        // overlong frame: dropped silently
        frame_count_next = '0;
        stage_next       = uli_pkg::STG_PREFIX;
        chars_next       = '0;
        prefix_good_next = 1'b1;
        match1_next      = 3'b111;
        match2_next      = 3'b111;
        pend_next        = uli_pkg::PEND_NONE;
        sealed_next      = 1'b0;
      end else begin
        frame_count_next = frame_count + 8'd1;
        case (stage)
          uli_pkg::STG_PREFIX: begin
            if (rx_byte != prefix_char(session, frame_count)) prefix_good_next = 1'b0;
            if (frame_count >= (session ? uli_pkg::CMD_PREFIX_LAST
                                        : uli_pkg::LOGIN_PREFIX_LAST))
              stage_next = uli_pkg::STG_FIRST;
          end
          uli_pkg::STG_FIRST, uli_pkg::STG_SECOND: begin
            if (!session) limit = CW'(NAME_CHARS);
            else limit = fld ? uli_pkg::STATUS_LIMIT : uli_pkg::DEVICE_LIMIT;
            if (rx_byte == uli_pkg::SEP_CHAR) begin
              if (fld) match2_next = close_mask(match2, 1'b1, chars, sealed, session, creds);
              else     match1_next = close_mask(match1, 1'b0, chars, sealed, session, creds);
              stage_next  = fld ? uli_pkg::STG_DONE : uli_pkg::STG_SECOND;
              chars_next  = '0;
              sealed_next = 1'b0;
            end else if (chars >= limit) begin
              pend_next  = fld ? uli_pkg::PEND_SECOND : uli_pkg::PEND_FIRST;
              stage_next = uli_pkg::STG_DONE;
            end else begin
              if (fld) match2_next = feed_mask(match2, 1'b1, chars, rx_byte, sealed,
                                               session, creds);
              else     match1_next = feed_mask(match1, 1'b0, chars, rx_byte, sealed,
                                               session, creds);
              sealed_next = sealed | (rx_byte == 8'h00);
              chars_next  = chars + CW'(1);
            end
          end
          default: ;
        endcase

        if (frame_end) begin
          // close whatever field is open; a missing second field is empty
          if (stage_next == uli_pkg::STG_FIRST) begin
            match1_next = close_mask(match1_next, 1'b0, chars_next, sealed_next,
                                     session, creds);
            match2_next = close_mask(match2_next, 1'b1, '0, 1'b0, session, creds);
          end else if (stage_next == uli_pkg::STG_SECOND) begin
            match2_next = close_mask(match2_next, 1'b1, chars_next, sealed_next,
                                     session, creds);
          end

          if (!session) begin
            if (frame_count_next < uli_pkg::LOGIN_MIN_LEN)
              res.status_code = uli_pkg::ST_TOO_SHORT;
            else if (!prefix_good_next)
              res.status_code = uli_pkg::ST_BAD_CRED;
            else if (pend_next != uli_pkg::PEND_NONE)
              res.status_code = uli_pkg::ST_FIELD_LONG;
            else if (match1_next[0] && match2_next[0]) begin
              session_next    = 1'b1;
              res.status_code = uli_pkg::ST_LOGIN_OK;
            end else
              res.status_code = uli_pkg::ST_BAD_CRED;
          end else begin
            if (frame_count_next < uli_pkg::CMD_MIN_LEN || !prefix_good_next)
              res.status_code = uli_pkg::ST_CMD_ERR;
            else if (pend_next == uli_pkg::PEND_FIRST)
              res.status_code = uli_pkg::ST_DEV_LONG;
            else if (pend_next == uli_pkg::PEND_SECOND)
              res.status_code = uli_pkg::ST_STAT_LONG;
            else if (match1_next[0]) begin
              if (match2_next[0]) begin
                lamp_next = 1'b1; res.status_code = uli_pkg::ST_CMD_OK;
              end else if (match2_next[1]) begin
                lamp_next = 1'b0; res.status_code = uli_pkg::ST_CMD_OK;
              end
            end else if (match1_next[1]) begin
              if (match2_next[0]) begin
                buzz_next = 1'b1; res.status_code = uli_pkg::ST_CMD_OK;
              end else if (match2_next[1]) begin
                buzz_next = 1'b0; res.status_code = uli_pkg::ST_CMD_OK;
              end
            end else if (match1_next[2] && match2_next[2]) begin
              session_next    = 1'b0;
              res.status_code = uli_pkg::ST_CMD_OK;
            end
          end
          res_valid = 1'b1;

          frame_count_next = '0;
          stage_next       = uli_pkg::STG_PREFIX;
          chars_next       = '0;
          prefix_good_next = 1'b1;
          match1_next      = 3'b111;
          match2_next      = 3'b111;
          pend_next        = uli_pkg::PEND_NONE;
          sealed_next      = 1'b0;
        end
      end
    end
    res.led_on    = lamp_next;
    res.beep_on   = buzz_next;
    res.logged_in = session_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= '0;
      stage       <= uli_pkg::STG_PREFIX;
      chars       <= '0;
      prefix_good <= 1'b1;
      match1      <= 3'b111;
      match2      <= 3'b111;
      pend        <= uli_pkg::PEND_NONE;
      sealed      <= 1'b0;
      session     <= 1'b0;
      lamp        <= 1'b0;
      buzz        <= 1'b0;
    end else begin
      frame_count <= frame_count_next;
      stage       <= stage_next;
      chars       <= chars_next;
      prefix_good <= prefix_good_next;
      match1      <= match1_next;
      match2      <= match2_next;
      pend        <= pend_next;
      sealed      <= sealed_next;
      session     <= session_next;
      lamp        <= lamp_next;
      buzz        <= buzz_next;
    end
  end

  `ULI_ASSERT_IMPL(a_res_needs_step, res_valid, step_en)
  `ULI_ASSERT_NEXT(a_frame_restarts, res_valid, frame_count == 8'd0 && prefix_good)
  `ULI_ASSERT_NEXT(a_session_on_result, !res_valid, $stable(session))
  `ULI_ASSERT_IMPL(a_count_bound, 1'b1, frame_count < 8'(MAX_FRAME))

endmodule

// ===== rtl/uart_login_command_interpreter_core.sv =====
// Top level of the serial login and command interpreter.
//
// Takes received bytes one per request on the s_axis side, tlast marking the
// last byte of a frame. Logged out, a frame "login#<user>#<pass>#" is checked
// against the credentials held in six configuration registers (username then
// password, each as low/mid/high words, first character in the low byte, zero
// padded, both "admin" after reset). Logged in, "cmd#<device>#<status>#"
// switches LED1 or BEEP ON/OFF, or "cmd#login#out#" logs out. Every completed
// frame yields exactly one result request on m_axis with a status code and the
// LED, buzzer and login state after the frame; a frame reaching MAX_FRAME bytes
// is discarded with no result and the following byte starts a new frame.
// Rate: one byte per clock sustained while m_axis is not stalled. The frame's
// last byte is held in the input register, and the frame engine's state update
// loads the result register from it once the result slot is free or emptying.
// s_axis_tready drops only while a result is held by a stalled m_axis. The
// configuration channel is always ready; write it only while no frame is in
// progress and no result is outstanding.
module uart_login_command_interpreter_core #(
  parameter int unsigned MAX_FRAME  = uli_pkg::MAX_FRAME_DEF,
  parameter int unsigned NAME_CHARS = uli_pkg::NAME_CHARS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic        s_axis_tlast,   // frame_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [2:0] status_code, [3] led_on, [4] beep_on,
                                      // [5] logged_in, [7:6] zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  uli_pkg::cred_t   creds;
  uli_pkg::result_t eng_res;
  logic             eng_valid;

  // input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;
  // result register
  logic             out_valid;
  uli_pkg::result_t out_res;

  logic drain;

  // the held byte moves on once the result slot is free or emptying
  assign drain         = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || drain;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  uli_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .creds     (creds)
  );

  uli_frame_engine #(
    .MAX_FRAME  (MAX_FRAME),
    .NAME_CHARS (NAME_CHARS)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .step_en   (drain),
    .rx_byte   (in_byte),
    .frame_end (in_last),
    .creds     (creds),
    .res_valid (eng_valid),
    .res       (eng_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (drain && eng_valid) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (drain && eng_valid) out_res <= eng_res;
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {2'b00, out_res.logged_in, out_res.beep_on, out_res.led_on,
                          out_res.status_code};

endmodule
